>>> src/hkr_pkg.sv
// Shared types, constants and usage-to-key lookup for the keyboard report translator.
`timescale 1ns / 1ps

package hkr_pkg;

  localparam int unsigned KEY_SLOTS   = 6;
  localparam int unsigned SLOT_FIELDS = 6;
  localparam int unsigned LANES       = (KEY_SLOTS < SLOT_FIELDS) ? KEY_SLOTS : SLOT_FIELDS;
  localparam int unsigned LANE_W      = (LANES > 1) ? $clog2(LANES) : 1;

  localparam int unsigned USAGE_COUNT = 256;
  localparam int unsigned USAGE_W     = 8;
  localparam int unsigned CODE_W      = 8;

  localparam int unsigned ROM_DEPTH   = 58;
  localparam int unsigned ROM_IDX_W   = $clog2(ROM_DEPTH);

  // Release scan walks the mapped usage range in groups.
  localparam int unsigned GRP_SIZE    = 8;
  localparam int unsigned BIT_W       = $clog2(GRP_SIZE);
  localparam int unsigned REL_GROUPS  = (ROM_DEPTH + GRP_SIZE - 1) / GRP_SIZE;
  localparam int unsigned GRP_W       = (REL_GROUPS > 1) ? $clog2(REL_GROUPS) : 1;
  localparam int unsigned REL_BITS    = REL_GROUPS * GRP_SIZE;

  localparam logic [1:0] EVT_CONNECT    = 2'd0;
  localparam logic [1:0] EVT_DISCONNECT = 2'd1;
  localparam logic [1:0] EVT_REPORT     = 2'd2;
  localparam logic [1:0] EVT_OTHER      = 2'd3;

  localparam logic [CODE_W-1:0] KC_ENTER     = 8'd13;
  localparam logic [CODE_W-1:0] KC_ESCAPE    = 8'd27;
  localparam logic [CODE_W-1:0] KC_BACKSPACE = 8'd127;
  localparam logic [CODE_W-1:0] KC_TAB       = 8'd9;
  localparam logic [CODE_W-1:0] KC_SPACE     = 8'd32;
  localparam logic [CODE_W-1:0] KC_CAPSLOCK  = 8'd128;

  localparam logic [CODE_W-1:0] USAGE_ROM [ROM_DEPTH] = '{
    8'h00, 8'h00, 8'h00, 8'h00,
    8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69,
    8'h6a, 8'h6b, 8'h6c, 8'h6d, 8'h6e, 8'h6f, 8'h70, 8'h71, 8'h72,
    8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7a,
    8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
    KC_ENTER, KC_ESCAPE, KC_BACKSPACE, KC_TAB, KC_SPACE,
    8'h2d, 8'h3d, 8'h5b, 8'h5d, 8'h5c, 8'h5c, 8'h3b, 8'h27, 8'h60,
    8'h2c, 8'h2e, 8'h2f,
    KC_CAPSLOCK
  };

  typedef struct packed {
    logic [1:0]         event_type;
    logic [USAGE_W-1:0] key_slot_0;
    logic [USAGE_W-1:0] key_slot_1;
    logic [USAGE_W-1:0] key_slot_2;
    logic [USAGE_W-1:0] key_slot_3;
    logic [USAGE_W-1:0] key_slot_4;
    logic [USAGE_W-1:0] key_slot_5;
  } in_req_t;

  typedef struct packed {
    logic [CODE_W-1:0]  key_code;
    logic               key_down;
    logic [USAGE_W-1:0] usage_code;
    logic               last_event;
  } out_req_t;

  // What one lane reports about its slot.
  typedef struct packed {
    logic               press;
    logic [CODE_W-1:0]  key_code;
    logic [USAGE_W-1:0] usage;
  } lane_rsp_t;

  function automatic logic usage_valid(input logic [USAGE_W-1:0] u);
    return (u != '0) && (32'(u) < USAGE_COUNT);
  endfunction

  function automatic logic [CODE_W-1:0] rom_lookup(input logic [USAGE_W-1:0] u);
    if ((32'(u) < ROM_DEPTH) && (32'(u) < USAGE_COUNT)) begin
      return USAGE_ROM[u[ROM_IDX_W-1:0]];
    end
    return '0;
  endfunction

endpackage

>>> src/hkr_lane.sv
// One slot lane: decide whether the slot's usage is a new, mapped press.
`timescale 1ns / 1ps

module hkr_lane (
  input  logic [hkr_pkg::LANE_W-1:0]  lane_idx,
  input  logic [hkr_pkg::USAGE_W-1:0] usage,
  input  logic [hkr_pkg::USAGE_W-1:0] cur      [hkr_pkg::LANES],
  input  logic [hkr_pkg::USAGE_W-1:0] prev     [hkr_pkg::LANES],
  input  logic [hkr_pkg::LANES-1:0]   prev_vld,
  output hkr_pkg::lane_rsp_t          rsp
);

  logic                        held;
  logic                        dup;
  logic [hkr_pkg::CODE_W-1:0]  code;

  always_comb begin
    held = 1'b0;
    dup  = 1'b0;
    for (int j = 0; j < hkr_pkg::LANES; j++) begin
      if (prev_vld[j] && (prev[j] == usage)) begin
        held = 1'b1;
      end
      // an earlier slot with the same usage owns the press
      if ((hkr_pkg::LANE_W'(j) < lane_idx) && (cur[j] == usage)) begin
        dup = 1'b1;
      end
    end
    code         = hkr_pkg::rom_lookup(usage);
    rsp.press    = hkr_pkg::usage_valid(usage) && !held && !dup && (code != '0);
    rsp.key_code = code;
    rsp.usage    = usage;
  end

endmodule

>>> src/hkr_merge.sv
// Merge stage: order press and release events, hold one back to tag the last one.
`timescale 1ns / 1ps

module hkr_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  hkr_pkg::lane_rsp_t            lane_rsp [hkr_pkg::LANES],
  input  logic [hkr_pkg::REL_BITS-1:0]  rel_mask,
  output logic                          done,
  output logic                          out_valid,
  input  logic                          out_stall,
  output hkr_pkg::out_req_t             out_req
);

  typedef enum logic [1:0] {
    M_IDLE,
    M_PRESS,
    M_REL,
    M_FLUSH
  } mstate_t;

  mstate_t                       state_r,      state_nxt;
  logic [hkr_pkg::LANES-1:0]     press_mask_r, press_mask_nxt;
  logic [hkr_pkg::CODE_W-1:0]    code_r  [hkr_pkg::LANES];
  logic [hkr_pkg::CODE_W-1:0]    code_nxt[hkr_pkg::LANES];
  logic [hkr_pkg::USAGE_W-1:0]   usage_r [hkr_pkg::LANES];
  logic [hkr_pkg::USAGE_W-1:0]   usage_nxt[hkr_pkg::LANES];
  logic [hkr_pkg::REL_BITS-1:0]  rel_mask_r,   rel_mask_nxt;
  logic [hkr_pkg::GRP_W-1:0]     grp_r,        grp_nxt;
  logic                          pend_vld_r,   pend_vld_nxt;
  hkr_pkg::out_req_t             pend_r,       pend_nxt;
  logic                          out_vld_r,    out_vld_nxt;
  hkr_pkg::out_req_t             out_r,        out_nxt;

  logic                          out_free;
  logic                          adv;
  logic                          p_hit;
  logic [hkr_pkg::LANE_W-1:0]    p_idx;
  logic [hkr_pkg::GRP_SIZE-1:0]  slice;
  logic                          r_hit;
  logic [hkr_pkg::BIT_W-1:0]     r_bit;
  logic [hkr_pkg::USAGE_W-1:0]   r_usage;
  logic                          new_ev;
  hkr_pkg::out_req_t             ev;

  assign out_free = !out_vld_r || !out_stall;
  // a new event may only displace the pending one if the output can take it
  assign adv      = !pend_vld_r || out_free;

  always_comb begin
    p_hit = |press_mask_r;
    p_idx = '0;
    for (int i = hkr_pkg::LANES - 1; i >= 0; i--) begin
      if (press_mask_r[i]) begin
        p_idx = hkr_pkg::LANE_W'(i);
      end
    end
    slice = rel_mask_r[{grp_r, hkr_pkg::BIT_W'(0)} +: hkr_pkg::GRP_SIZE];
    r_hit = |slice;
    r_bit = '0;
    for (int b = hkr_pkg::GRP_SIZE - 1; b >= 0; b--) begin
      if (slice[b]) begin
        r_bit = hkr_pkg::BIT_W'(b);
      end
    end
    r_usage = hkr_pkg::USAGE_W'({grp_r, r_bit});
  end

  always_comb begin
    state_nxt      = state_r;
    press_mask_nxt = press_mask_r;
    code_nxt       = code_r;
    usage_nxt      = usage_r;
    rel_mask_nxt   = rel_mask_r;
    grp_nxt        = grp_r;
    pend_vld_nxt   = pend_vld_r;
    pend_nxt       = pend_r;
    out_vld_nxt    = out_vld_r && out_stall;
    out_nxt        = out_r;
    done           = 1'b0;
    new_ev         = 1'b0;
    ev             = '0;

    unique case (state_r)
      M_IDLE: begin
        if (start) begin
          for (int i = 0; i < hkr_pkg::LANES; i++) begin
            press_mask_nxt[i] = lane_rsp[i].press;
            code_nxt[i]       = lane_rsp[i].key_code;
            usage_nxt[i]      = lane_rsp[i].usage;
          end
          rel_mask_nxt = rel_mask;
          grp_nxt      = '0;
          state_nxt    = M_PRESS;
        end
      end
      M_PRESS: begin
        if (adv) begin
          if (p_hit) begin
            new_ev               = 1'b1;
            ev.key_code          = code_r[p_idx];
            ev.key_down          = 1'b1;
            ev.usage_code        = usage_r[p_idx];
            ev.last_event        = 1'b0;
            press_mask_nxt[p_idx] = 1'b0;
          end else begin
            state_nxt = M_REL;
          end
        end
      end
      M_REL: begin
        if (adv) begin
          if (r_hit) begin
            new_ev                          = 1'b1;
            ev.key_code                     = hkr_pkg::rom_lookup(r_usage);
            ev.key_down                     = 1'b0;
            ev.usage_code                   = r_usage;
            ev.last_event                   = 1'b0;
            rel_mask_nxt[{grp_r, r_bit}]    = 1'b0;
          end else if (grp_r == hkr_pkg::GRP_W'(hkr_pkg::REL_GROUPS - 1)) begin
            state_nxt = M_FLUSH;
          end else begin
            grp_nxt = grp_r + 1'b1;
          end
        end
      end
      M_FLUSH: begin
        if (!pend_vld_r) begin
          done      = 1'b1;
          state_nxt = M_IDLE;
        end else if (out_free) begin
          out_vld_nxt        = 1'b1;
          out_nxt            = pend_r;
          out_nxt.last_event = 1'b1;
          pend_vld_nxt       = 1'b0;
          done               = 1'b1;
          state_nxt          = M_IDLE;
        end
      end
      default: begin
        state_nxt = M_IDLE;
      end
    endcase

    if (new_ev) begin
      if (pend_vld_r) begin
        out_vld_nxt = 1'b1;
        out_nxt     = pend_r;
      end
      pend_vld_nxt = 1'b1;
      pend_nxt     = ev;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= M_IDLE;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
    press_mask_r <= press_mask_nxt;
    code_r       <= code_nxt;
    usage_r      <= usage_nxt;
    rel_mask_r   <= rel_mask_nxt;
    grp_r        <= grp_nxt;
    pend_r       <= pend_nxt;
    out_r        <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_req   = out_r;

endmodule

>>> src/hid_keyboard_report_to_key_events_top.sv
// Top level of the keyboard report translator: input register, held-key set, lanes, merge.
// Each event is held back in the merge stage until the next one arrives, to tag the last
// one, so a report with a single event waits for the release scan to finish.
// The merge stage produces one event per cycle while the output does not stall, and walks
// its 8-group release scan; the input stalls until it is done with the report.
// Connect, disconnect and unknown requests give no event and leave the block idle. Reset
// (rst_n low, synchronous) empties the held-key set and drops any pending event.
`timescale 1ns / 1ps

module hid_keyboard_report_to_key_events_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  hkr_pkg::in_req_t   in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output hkr_pkg::out_req_t  out_req
);

  // Held-key set: after every report the held usages are exactly the valid
  // usages that report listed, so the previous report's slots stand in for
  // the full usage map.
  logic [hkr_pkg::USAGE_W-1:0] prev_r     [hkr_pkg::LANES];
  logic [hkr_pkg::LANES-1:0]   prev_vld_r;
  logic [hkr_pkg::USAGE_W-1:0] cur_r      [hkr_pkg::LANES];
  logic [hkr_pkg::USAGE_W-1:0] slot_in    [hkr_pkg::SLOT_FIELDS];

  logic                        busy_r;
  logic                        start_r;
  logic                        accept;
  logic                        accept_rep;
  logic                        done;

  hkr_pkg::lane_rsp_t          lane_rsp   [hkr_pkg::LANES];
  logic [hkr_pkg::REL_BITS-1:0] rel_mask;
  logic                        held_u;
  logic                        listed_u;

  // One report at a time: stall from acceptance until the merge stage is done.
  assign in_stall   = busy_r;
  assign accept     = in_valid && !in_stall;
  assign accept_rep = accept && (in_req.event_type == hkr_pkg::EVT_REPORT);

  always_comb begin
    slot_in[0] = in_req.key_slot_0;
    slot_in[1] = in_req.key_slot_1;
    slot_in[2] = in_req.key_slot_2;
    slot_in[3] = in_req.key_slot_3;
    slot_in[4] = in_req.key_slot_4;
    slot_in[5] = in_req.key_slot_5;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b0;
      start_r    <= 1'b0;
      prev_vld_r <= '0;
    end else begin
      start_r <= accept_rep;
      // hold busy from a report's acceptance until the last event is handed off
      if (accept_rep) begin
        busy_r <= 1'b1;
      end else if (done) begin
        busy_r <= 1'b0;
      end
      // advance the held set once the lanes and release map have sampled it
      if (start_r) begin
        for (int i = 0; i < hkr_pkg::LANES; i++) begin
          prev_vld_r[i] <= hkr_pkg::usage_valid(cur_r[i]);
        end
      end
    end
    if (accept_rep) begin
      for (int i = 0; i < hkr_pkg::LANES; i++) begin
        cur_r[i] <= slot_in[i];
      end
    end
    if (start_r) begin
      prev_r <= cur_r;
    end
  end

  // Slot lanes: each checks its own usage against the held set and the
  // earlier slots of the same report.
  for (genvar gi = 0; gi < hkr_pkg::LANES; gi++) begin : g_lane
    hkr_lane u_lane (
      .lane_idx (hkr_pkg::LANE_W'(gi)),
      .usage    (cur_r[gi]),
      .cur      (cur_r),
      .prev     (prev_r),
      .prev_vld (prev_vld_r),
      .rsp      (lane_rsp[gi])
    );
  end

  // Release map over the mapped usage range: held, no longer listed, and
  // translating to a nonzero key code. Unmapped usages drop silently.
  always_comb begin
    rel_mask = '0;
    held_u   = 1'b0;
    listed_u = 1'b0;
    for (int u = 0; u < hkr_pkg::REL_BITS; u++) begin
      held_u   = 1'b0;
      listed_u = 1'b0;
      for (int j = 0; j < hkr_pkg::LANES; j++) begin
        if (prev_vld_r[j] && (prev_r[j] == hkr_pkg::USAGE_W'(u))) begin
          held_u = 1'b1;
        end
        if (cur_r[j] == hkr_pkg::USAGE_W'(u)) begin
          listed_u = 1'b1;
        end
      end
      rel_mask[u] = held_u && !listed_u &&
                    (hkr_pkg::rom_lookup(hkr_pkg::USAGE_W'(u)) != '0);
    end
  end

  // Merge stage: presses in slot order, then releases in ascending usage order.
  hkr_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_r),
    .lane_rsp  (lane_rsp),
    .rel_mask  (rel_mask),
    .done      (done),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_req   (out_req)
  );

`ifndef SYNTH
  a_report_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    accept_rep |=> in_stall)
    else $error("key report accepted without stalling the input");

  a_other_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !accept_rep) |=> !in_stall)
    else $error("non-report request made the block busy");

  a_code_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_req.key_code != '0))
    else $error("event with an unmapped key code");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> busy_r)
    else $error("merge started while idle");
`endif

endmodule
